// ===== rtl/ssm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg
// types, constants and helpers for the sensor safety monitor
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int SAMPLE_W       = 12;
	localparam int TIME_W         = 32;
	localparam int GAIN_W         = 24;
	localparam int WIN_W          = 16;
	localparam int BUS_W          = 16;
	localparam int CUR_W          = 16;
	localparam int TEMP_W         = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;
	localparam int COUNT_BITS_DEF = 16;

	// sample validity window is exclusive at both ends
	localparam int VALID_LO     = 20;
	localparam int VALID_HI     = 4000;
	localparam int BUS_MIN_MV   = 2000;
	localparam int CUR_LIMIT_MA = 50;
	localparam int TEMP_LIMIT_C = 85;
	localparam int TEMP_DEF_C   = 25;
	localparam int HALF_Q16     = 32768;
	localparam int FRAC_BITS    = 16;

	localparam logic [GAIN_W-1:0] VBUS_GAIN_RST = GAIN_W'(52813);
	localparam logic [GAIN_W-1:0] CUR_GAIN_RST  = GAIN_W'(52813);
	localparam logic [GAIN_W-1:0] TEMP_GAIN_RST = GAIN_W'(5281);
	localparam logic [WIN_W-1:0]  CAL_WIN_RST   = WIN_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_EN    = 3'd0,
		REG_BYPASS    = 3'd1,
		REG_VBUS_GAIN = 3'd2,
		REG_CUR_GAIN  = 3'd3,
		REG_TEMP_GAIN = 3'd4,
		REG_CAL_WIN   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] vbus_sample;
		logic [SAMPLE_W-1:0] shunt_sample;
		logic [SAMPLE_W-1:0] temp_sample;
		logic [TIME_W-1:0]   now_ms;
		logic                driver_on;
	} sample_t;

	typedef struct packed {
		logic [BUS_W-1:0]        bus_mv;
		logic signed [CUR_W-1:0] current_ma;
		logic [TEMP_W-1:0]       temp_c;
		logic                    current_ok;
		logic                    temp_ok;
		logic                    safe;
		logic                    offset_ready;
		logic [SAMPLE_W-1:0]     offset_value;
		logic                    driver_off_request;
	} result_t;

	function automatic logic in_window(input logic [SAMPLE_W-1:0] s);
		in_window = (s > SAMPLE_W'(VALID_LO)) && (s < SAMPLE_W'(VALID_HI));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sensor_safety_monitor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_safety_monitor_top
// flow: S_VBUS, S_CUR, S_TEMP, S_CAL, then S_DONE; S_DIV comes between when the
//   shunt offset is computed (12-step restoring divider)
// a new word is accepted only in S_IDLE, once the last one is done; the single
//   shared 13x25 multiplier makes three passes, the divider one bit a cycle
// reset: asynchronous, restores register defaults and clears calibration state
// ----------------------------------------------------------------------------
module sensor_safety_monitor_top #(
	parameter int COUNT_BITS = ssm_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  ssm_pkg::sample_t               sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output ssm_pkg::result_t               result
);
	import ssm_pkg::*;

	localparam int SUM_W   = SAMPLE_W + COUNT_BITS;
	localparam int QUO_W   = SAMPLE_W;
	localparam int STEP_W  = $clog2(QUO_W);
	localparam int MUL_A_W = SAMPLE_W + 1;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int RND_W   = PROD_W - FRAC_BITS;
	localparam int CUR_MIN_I = -(2 ** (CUR_W - 1));

	localparam logic [STEP_W-1:0]     LAST_STEP  = STEP_W'(QUO_W - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic signed [PROD_W-1:0] HALF_P  = PROD_W'(HALF_Q16);
	localparam logic signed [RND_W-1:0]  BUS_MAX_R  = RND_W'(2 ** BUS_W - 1);
	localparam logic signed [RND_W-1:0]  CUR_MAX_R  = RND_W'(2 ** (CUR_W - 1) - 1);
	localparam logic signed [RND_W-1:0]  CUR_MIN_R  = RND_W'(CUR_MIN_I);
	localparam logic signed [RND_W-1:0]  TEMP_MAX_R = RND_W'(2 ** TEMP_W - 1);
	localparam logic signed [CUR_W-1:0]  CUR_LIM_P  = CUR_W'(CUR_LIMIT_MA);
	localparam logic signed [CUR_W-1:0]  CUR_LIM_N  = CUR_W'(-CUR_LIMIT_MA);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_VBUS = 7'b0000010,
		S_CUR  = 7'b0000100,
		S_TEMP = 7'b0001000,
		S_CAL  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic              cal_en_q;
	logic              bypass_q;
	logic [GAIN_W-1:0] vbus_gain_q;
	logic [GAIN_W-1:0] cur_gain_q;
	logic [GAIN_W-1:0] temp_gain_q;
	logic [WIN_W-1:0]  cal_win_q;

	// word under work
	logic [SAMPLE_W-1:0] vb_q;
	logic [SAMPLE_W-1:0] sh_q;
	logic [SAMPLE_W-1:0] tp_q;
	logic [TIME_W-1:0]   now_q;
	logic                drv_q;

	logic signed [PROD_W-1:0] prod_q;
	logic [BUS_W-1:0]         bus_q;
	logic signed [CUR_W-1:0]  cur_q;
	logic [TEMP_W-1:0]        temp_q;
	logic                     start_req_q;

	// calibration state
	logic                  win_started_q;
	logic [TIME_W-1:0]     win_start_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [SAMPLE_W-1:0]   offset_q;
	logic                  offset_valid_q;

	// divider
	logic [SUM_W-1:0]    rem_q;
	logic [SUM_W-1:0]    dsh_q;
	logic [QUO_W-1:0]    quo_q;
	logic [STEP_W-1:0]   step_q;

	result_t result_q;
	logic    result_valid_q;

	// shared multiplier and rounding
	logic signed [MUL_A_W-1:0] corr;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  rnd_full;
	logic signed [RND_W-1:0]   rnd;
	logic [BUS_W-1:0]          bus_sat;
	logic signed [CUR_W-1:0]   cur_sat;
	logic [TEMP_W-1:0]         temp_sat;

	// calibration update
	logic                  start_c;
	logic [TIME_W-1:0]     ws_c;
	logic [SUM_W-1:0]      sum_b;
	logic [COUNT_BITS-1:0] cnt_b;
	logic                  ov_b;
	logic [SUM_W-1:0]      sum_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic [TIME_W-1:0]     elapsed;
	logic                  div_go;
	logic                  div_ge;

	// result assembly
	logic                cur_ok;
	logic                t_ok;
	logic                cur_big;
	logic                safe_c;
	logic [TEMP_W-1:0]   temp_out;
	logic                out_free;
	result_t             result_c;

	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	// offset applies only once the previous calibration produced one
	assign corr = {1'b0, sh_q} - (offset_valid_q ? {1'b0, offset_q} : {MUL_A_W{1'b0}});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_VBUS: begin
				mul_a = {1'b0, vb_q};
				mul_b = {1'b0, vbus_gain_q};
			end
			S_CUR: begin
				mul_a = corr;
				mul_b = {1'b0, cur_gain_q};
			end
			S_TEMP: begin
				mul_a = {1'b0, tp_q};
				mul_b = {1'b0, temp_gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign rnd_full = prod_q + HALF_P;
	assign rnd      = $signed(rnd_full[PROD_W-1:FRAC_BITS]);

	assign bus_sat  = (rnd > BUS_MAX_R) ? {BUS_W{1'b1}} : rnd[BUS_W-1:0];
	assign temp_sat = (rnd > TEMP_MAX_R) ? {TEMP_W{1'b1}} : rnd[TEMP_W-1:0];

	always_comb begin
		if (rnd > CUR_MAX_R) begin
			cur_sat = {1'b0, {(CUR_W-1){1'b1}}};
		end else if (rnd < CUR_MIN_R) begin
			cur_sat = {1'b1, {(CUR_W-1){1'b0}}};
		end else begin
			cur_sat = rnd[CUR_W-1:0];
		end
	end

	// a new window restarts the sum and count before this word is added
	assign start_c = !win_started_q;
	assign ws_c    = start_c ? now_q : win_start_q;
	assign sum_b   = start_c ? '0 : sum_q;
	assign cnt_b   = start_c ? '0 : cnt_q;
	assign ov_b    = start_c ? 1'b0 : offset_valid_q;
	assign sum_n   = (cnt_b == COUNT_MAX) ? sum_b : sum_b + SUM_W'(sh_q);
	assign cnt_n   = (cnt_b == COUNT_MAX) ? cnt_b : cnt_b + 1'b1;
	assign elapsed = now_q - ws_c;
	assign div_go  = !ov_b && (elapsed >= TIME_W'(cal_win_q));
	assign div_ge  = (rem_q >= dsh_q);

	assign cur_ok   = in_window(sh_q);
	assign t_ok     = in_window(tp_q);
	assign cur_big  = cur_ok && ((cur_q > CUR_LIM_P) || (cur_q < CUR_LIM_N));
	assign temp_out = (bypass_q || !t_ok) ? TEMP_W'(TEMP_DEF_C) : temp_q;
	assign safe_c   = bypass_q || !((bus_q < BUS_W'(BUS_MIN_MV)) || cur_big
		|| (t_ok && (temp_q > TEMP_W'(TEMP_LIMIT_C))) || drv_q);

	always_comb begin
		result_c.bus_mv             = bus_q;
		result_c.current_ma         = cur_q;
		result_c.temp_c             = temp_out;
		result_c.current_ok         = cur_ok;
		result_c.temp_ok            = t_ok;
		result_c.safe               = safe_c;
		result_c.offset_ready       = offset_valid_q;
		result_c.offset_value       = offset_q;
		result_c.driver_off_request = start_req_q;
	end

	// sequencer, configuration and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cal_en_q       <= 1'b0;
			bypass_q       <= 1'b1;
			vbus_gain_q    <= VBUS_GAIN_RST;
			cur_gain_q     <= CUR_GAIN_RST;
			temp_gain_q    <= TEMP_GAIN_RST;
			cal_win_q      <= CAL_WIN_RST;
			win_started_q  <= 1'b0;
			win_start_q    <= '0;
			sum_q          <= '0;
			cnt_q          <= '0;
			offset_q       <= '0;
			offset_valid_q <= 1'b0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// the output step raises valid itself
			if (result_valid_q && !result_stall && (state_q != S_DONE)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_VBUS;
					end
				end
				S_VBUS: state_q <= S_CUR;
				S_CUR:  state_q <= S_TEMP;
				S_TEMP: state_q <= S_CAL;
				S_CAL: begin
					if (cal_en_q) begin
						win_started_q  <= 1'b1;
						win_start_q    <= ws_c;
						sum_q          <= sum_n;
						cnt_q          <= cnt_n;
						offset_valid_q <= ov_b;
						step_q         <= LAST_STEP;
						state_q        <= div_go ? S_DIV : S_DONE;
					end else begin
						win_started_q <= 1'b0;
						sum_q         <= '0;
						cnt_q         <= '0;
						state_q       <= S_DONE;
					end
				end
				S_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						offset_q       <= {quo_q[QUO_W-2:0], div_ge};
						offset_valid_q <= 1'b1;
						state_q        <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_CAL_EN: begin
						cal_en_q <= cfg_data[0];
						if (cfg_data[0]) begin
							win_started_q  <= 1'b0;
							sum_q          <= '0;
							cnt_q          <= '0;
							offset_valid_q <= 1'b0;
						end
					end
					REG_BYPASS:    bypass_q    <= cfg_data[0];
					REG_VBUS_GAIN: vbus_gain_q <= cfg_data[GAIN_W-1:0];
					REG_CUR_GAIN:  cur_gain_q  <= cfg_data[GAIN_W-1:0];
					REG_TEMP_GAIN: temp_gain_q <= cfg_data[GAIN_W-1:0];
					REG_CAL_WIN:   cal_win_q   <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					vb_q  <= sample.vbus_sample;
					sh_q  <= sample.shunt_sample;
					tp_q  <= sample.temp_sample;
					now_q <= sample.now_ms;
					drv_q <= sample.driver_on;
				end
			end
			S_VBUS: prod_q <= mul_p;
			S_CUR: begin
				bus_q  <= bus_sat;
				prod_q <= mul_p;
			end
			S_TEMP: begin
				cur_q  <= cur_ok ? cur_sat : '0;
				prod_q <= mul_p;
			end
			S_CAL: begin
				temp_q      <= temp_sat;
				start_req_q <= cal_en_q && start_c;
				rem_q       <= sum_n;
				dsh_q       <= SUM_W'(cnt_n) << (QUO_W - 1);
			end
			S_DIV: begin
				// restoring division, one quotient bit a cycle
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
			end
			S_DONE: begin
				if (out_free) begin
					result_q <= result_c;
				end
			end
			default: ;
		endcase
	end

	a_offset_from_divider: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(offset_valid_q) |-> $past(state_q == S_DIV))
		else $error("offset became valid outside the divider");

	a_divider_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && step_q == '0) |=> (offset_valid_q && state_q == S_DONE))
		else $error("last divider step did not publish the offset");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word raised outside the output step");

	a_cal_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CAL && !cal_en_q && !cfg_we) |=> (cnt_q == '0 && !win_started_q))
		else $error("calibration state kept while calibration is off");

endmodule
`default_nettype wire
